>>> sv/lree_pkg.sv
// ----------------------------------------------------------------------------
// lree_pkg
// Shared types, codes and the fixed parse tables of the LR expression
// evaluator: action table, goto table and rule properties.
// ----------------------------------------------------------------------------
package lree_pkg;

  // Stack geometry.
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned VAL_W       = 32;

  // Token kinds.
  localparam logic [2:0] TOK_NUM    = 3'd0;
  localparam logic [2:0] TOK_PLUS   = 3'd1;
  localparam logic [2:0] TOK_STAR   = 3'd2;
  localparam logic [2:0] TOK_LPAREN = 3'd3;
  localparam logic [2:0] TOK_RPAREN = 3'd4;
  localparam logic [2:0] TOK_END    = 3'd5;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SYNTAX   = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Nonterminals.
  localparam logic [1:0] NT_EXPR   = 2'd0;
  localparam logic [1:0] NT_TERM   = 2'd1;
  localparam logic [1:0] NT_FACTOR = 2'd2;

  // Grammar rules.
  localparam logic [2:0] RULE_ADD     = 3'd1;
  localparam logic [2:0] RULE_E_T     = 3'd2;
  localparam logic [2:0] RULE_MUL     = 3'd3;
  localparam logic [2:0] RULE_T_F     = 3'd4;
  localparam logic [2:0] RULE_PAREN   = 3'd5;
  localparam logic [2:0] RULE_F_NUM   = 3'd6;

  typedef enum logic [1:0] {
    ACT_ERROR,
    ACT_SHIFT,
    ACT_REDUCE,
    ACT_ACCEPT
  } act_kind_e;

  // Decoded action entry: shift target state or reduce rule in arg.
  typedef struct packed {
    act_kind_e  kind;
    logic [3:0] arg;
  } act_t;

  // One write port and the read addresses of both stacks.
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [3:0]       wstate;
    logic [VAL_W-1:0] wval;
    logic             re;
    logic [PTR_W-1:0] raddr_state;
    logic [PTR_W-1:0] raddr_val;
  } stack_req_t;

  function automatic act_t mk_act(act_kind_e kind, logic [3:0] arg);
    act_t a;
    a.kind = kind;
    a.arg  = arg;
    return a;
  endfunction

  // Action table lookup; unknown states and token kinds read as error.
  function automatic act_t lree_action(logic [3:0] st, logic [2:0] kind);
    act_t a;
    a = mk_act(ACT_ERROR, 4'd0);
    case (st)
      4'd0, 4'd4, 4'd6, 4'd7: begin
        if (kind == TOK_NUM)         a = mk_act(ACT_SHIFT, 4'd5);
        else if (kind == TOK_LPAREN) a = mk_act(ACT_SHIFT, 4'd4);
      end
      4'd1: begin
        if (kind == TOK_PLUS)        a = mk_act(ACT_SHIFT, 4'd6);
        else if (kind == TOK_END)    a = mk_act(ACT_ACCEPT, 4'd0);
      end
      4'd2, 4'd9: begin
        case (kind) inside
          TOK_STAR:                   a = mk_act(ACT_SHIFT, 4'd7);
          TOK_PLUS, TOK_RPAREN, TOK_END:
            a = mk_act(ACT_REDUCE, (st == 4'd2) ? {1'b0, RULE_E_T} : {1'b0, RULE_ADD});
          default:                    a = mk_act(ACT_ERROR, 4'd0);
        endcase
      end
      4'd3, 4'd5, 4'd10, 4'd11: begin
        case (kind) inside
          TOK_PLUS, TOK_STAR, TOK_RPAREN, TOK_END: begin
            case (st)
              4'd3:    a = mk_act(ACT_REDUCE, {1'b0, RULE_T_F});
              4'd5:    a = mk_act(ACT_REDUCE, {1'b0, RULE_F_NUM});
              4'd10:   a = mk_act(ACT_REDUCE, {1'b0, RULE_MUL});
              default: a = mk_act(ACT_REDUCE, {1'b0, RULE_PAREN});
            endcase
          end
          default: a = mk_act(ACT_ERROR, 4'd0);
        endcase
      end
      4'd8: begin
        if (kind == TOK_PLUS)        a = mk_act(ACT_SHIFT, 4'd6);
        else if (kind == TOK_RPAREN) a = mk_act(ACT_SHIFT, 4'd11);
      end
      default: a = mk_act(ACT_ERROR, 4'd0);
    endcase
    return a;
  endfunction

  // Goto table on a nonterminal.
  function automatic logic [3:0] lree_goto(logic [3:0] st, logic [1:0] nt);
    logic [3:0] g;
    g = 4'd0;
    case (st)
      4'd0: begin
        if (nt == NT_EXPR)        g = 4'd1;
        else if (nt == NT_TERM)   g = 4'd2;
        else if (nt == NT_FACTOR) g = 4'd3;
      end
      4'd4: begin
        if (nt == NT_EXPR)        g = 4'd8;
        else if (nt == NT_TERM)   g = 4'd2;
        else if (nt == NT_FACTOR) g = 4'd3;
      end
      4'd6: begin
        if (nt == NT_TERM)        g = 4'd9;
        else if (nt == NT_FACTOR) g = 4'd3;
      end
      4'd7: begin
        if (nt == NT_FACTOR)      g = 4'd10;
      end
      default: g = 4'd0;
    endcase
    return g;
  endfunction

  // Number of symbols on the right-hand side of a rule.
  function automatic logic [1:0] lree_rule_len(logic [2:0] rule);
    logic [1:0] n;
    case (rule)
      RULE_ADD, RULE_MUL, RULE_PAREN: n = 2'd3;
      default:                        n = 2'd1;
    endcase
    return n;
  endfunction

  // Left-hand nonterminal of a rule.
  function automatic logic [1:0] lree_rule_lhs(logic [2:0] rule);
    logic [1:0] n;
    case (rule)
      RULE_ADD, RULE_E_T: n = NT_EXPR;
      RULE_MUL, RULE_T_F: n = NT_TERM;
      default:            n = NT_FACTOR;
    endcase
    return n;
  endfunction

endpackage

>>> sv/lree_ifs.sv
// ----------------------------------------------------------------------------
// lree_ifs
// Valid/ready channels of the LR expression evaluator: token in, result out.
// ----------------------------------------------------------------------------
interface lree_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [30:0] token_value;

  modport source (output valid, output token_kind, output token_value, input ready);
  modport sink   (input valid, input token_kind, input token_value, output ready);
endinterface

interface lree_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] result_value;

  modport source (output valid, output status, output result_value, input ready);
  modport sink   (input valid, input status, input result_value, output ready);
endinterface

>>> sv/lr_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// lr_expression_evaluator_unit
// Table-driven LR parser and evaluator for E->E+T|T, T->T*F|F, F->(E)|num.
// ----------------------------------------------------------------------------
// Usage:
//   tok_i carries one lexed token per transfer (kind and, for numbers, value).
//   res_o carries one result per finished expression: status and value.
//   An accepted end token, a token with no parse action or a full stack
//   produces a result; all other tokens are absorbed silently.
// Sequencing:
//   A token passes through the action lookup and, per reduction that it
//   triggers, a registered stack read and the add, multiply or copy that
//   writes the new top. A single sequencer and one stack read port
//   serialise these steps. tok_i.ready is high only while the sequencer
//   waits for a token.
// Reset:
//   Clears sequencer, stack pointer, cached top state and result valid;
//   the stacks need no clearing since entries are always written before read.
// Stalls:
//   A pending result sits in an output register; a new token is still
//   taken, and processing only waits if a second result is due before the
//   first transfer. After any result the stacks start over empty.
// ----------------------------------------------------------------------------
module lr_expression_evaluator_unit
  import lree_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  lree_token_if.sink   tok_i,
  lree_result_if.source res_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ACT    = 2'd1;
  localparam logic [1:0] S_REDUCE = 2'd2;

  logic [1:0]       seq_q, seq_d;
  logic [PTR_W-1:0] top_q, top_d;
  logic [3:0]       top_state_q, top_state_d;
  logic [VAL_W-1:0] top_val_q, top_val_d;
  logic [2:0]       kind_q;
  logic [30:0]      tval_q;
  logic [PTR_W-1:0] base_q, base_d;
  logic [2:0]       rule_q, rule_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [VAL_W-1:0] out_value_q, out_value_d;

  stack_req_t       stack_req;
  logic [3:0]       state_rd;
  logic [VAL_W-1:0] val_rd;

  act_t             act;
  logic [PTR_W-1:0] len_w;
  logic             out_free;
  logic [3:0]       below;
  logic [PTR_W-1:0] new_top;

  lree_stack u_stack (
    .clk_i      (clk_i),
    .req_i      (stack_req),
    .state_rd_o (state_rd),
    .val_rd_o   (val_rd)
  );

  assign tok_i.ready        = (seq_q == S_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_status_q;
  assign res_o.result_value = $signed(out_value_q);

  assign act      = lree_action(top_state_q, kind_q);
  assign len_w    = PTR_W'(lree_rule_len(act.arg[2:0]));
  assign out_free = !out_valid_q || res_o.ready;
  assign below    = (base_q == '0) ? 4'd0 : state_rd;
  assign new_top  = base_q + PTR_W'(1);

  // Sequencer: action lookup, shifts, reduction steps and result output.
  always_comb begin
    seq_d        = seq_q;
    top_d        = top_q;
    top_state_d  = top_state_q;
    top_val_d    = top_val_q;
    base_d       = base_q;
    rule_d       = rule_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    stack_req    = '0;

    unique case (seq_q)
      S_IDLE: begin
        if (tok_i.valid) begin
          seq_d = S_ACT;
        end
      end
      S_ACT: begin
        if (act.kind == ACT_SHIFT && top_q != PTR_W'(STACK_DEPTH - 1)) begin
          // Push the new state with the token's value.
          top_d           = top_q + PTR_W'(1);
          top_state_d     = act.arg;
          top_val_d       = (kind_q == TOK_NUM) ? {1'b0, tval_q} : '0;
          stack_req.we    = 1'b1;
          stack_req.waddr = top_d;
          stack_req.wstate = top_state_d;
          stack_req.wval  = top_val_d;
          seq_d           = S_IDLE;
        end else if (act.kind == ACT_REDUCE && act.arg[2:0] != 3'd0 &&
                     act.arg[2:0] != 3'd7 && act.arg[3] == 1'b0 && top_q >= len_w) begin
          // Fetch the state below the handle and the operand value.
          base_d                = top_q - len_w;
          rule_d                = act.arg[2:0];
          stack_req.re          = 1'b1;
          stack_req.raddr_state = base_d;
          stack_req.raddr_val   = (act.arg[2:0] == RULE_PAREN) ? top_q - PTR_W'(1)
                                                               : top_q - PTR_W'(2);
          seq_d                 = S_REDUCE;
        end else if (out_free) begin
          // Accept, error or overflow: emit a result and start over.
          out_valid_d = 1'b1;
          out_value_d = '0;
          if (act.kind == ACT_ACCEPT) begin
            out_status_d = STATUS_OK;
            out_value_d  = top_val_q;
          end else if (act.kind == ACT_SHIFT) begin
            out_status_d = STATUS_OVERFLOW;
          end else begin
            out_status_d = STATUS_SYNTAX;
          end
          top_d       = '0;
          top_state_d = 4'd0;
          seq_d       = S_IDLE;
        end
      end
      S_REDUCE: begin
        // Evaluate the rule and replace the handle by the goto state.
        case (rule_q)
          RULE_ADD:   top_val_d = val_rd + top_val_q;
          RULE_MUL:   top_val_d = val_rd * top_val_q;
          RULE_PAREN: top_val_d = val_rd;
          default:    top_val_d = top_val_q;
        endcase
        top_d            = new_top;
        top_state_d      = lree_goto(below, lree_rule_lhs(rule_q));
        stack_req.we     = 1'b1;
        stack_req.waddr  = new_top;
        stack_req.wstate = top_state_d;
        stack_req.wval   = top_val_d;
        seq_d            = S_ACT;
      end
      default: seq_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= S_IDLE;
      top_q       <= '0;
      top_state_q <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      top_q       <= top_d;
      top_state_q <= top_state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (tok_i.valid && tok_i.ready) begin
      kind_q <= tok_i.token_kind;
      tval_q <= tok_i.token_value;
    end
    top_val_q    <= top_val_d;
    base_q       <= base_d;
    rule_q       <= rule_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

endmodule

>>> sv/lree_stack.sv
// ----------------------------------------------------------------------------
// lree_stack
// State and value stacks of the parser: one write port shared by both, one
// registered read port on each.
// ----------------------------------------------------------------------------
module lree_stack
  import lree_pkg::*;
(
  input  logic             clk_i,
  input  stack_req_t       req_i,
  output logic [3:0]       state_rd_o,
  output logic [VAL_W-1:0] val_rd_o
);

  logic [3:0]       state_mem [STACK_DEPTH];
  logic [VAL_W-1:0] val_mem   [STACK_DEPTH];

  // Write both stacks at the same entry.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      state_mem[req_i.waddr] <= req_i.wstate;
      val_mem[req_i.waddr]   <= req_i.wval;
    end
  end

  // Registered reads.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      state_rd_o <= state_mem[req_i.raddr_state];
      val_rd_o   <= val_mem[req_i.raddr_val];
    end
  end

endmodule

>>> sv/lree_checker.sv
// ----------------------------------------------------------------------------
// lree_checker
// Port-level checks of the LR expression evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module lree_checker
  import lree_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        tok_valid_i,
  input logic        tok_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [1:0]  res_status_i,
  input logic [31:0] res_value_i
);

  // A pending result stays until its transfer.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before transfer");

  // The block is busy in the cycle after each token transfer.
  a_busy_after_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_ready_i |=> !tok_ready_i)
    else $error("token taken while previous token still in work");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_status_i == STATUS_OK || res_status_i == STATUS_SYNTAX ||
                     res_status_i == STATUS_OVERFLOW))
    else $error("undefined status code");

  // Failed expressions carry a zero value.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i != STATUS_OK |-> res_value_i == 32'd0)
    else $error("error result with nonzero value");

endmodule

bind lr_expression_evaluator_unit lree_checker u_lree_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tok_valid_i  (tok_i.valid),
  .tok_ready_i  (tok_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.status),
  .res_value_i  (res_o.result_value)
);
